// ===== rtl/lqwc_pkg.sv =====
// Shared types and constants for the link quality window counter.
`default_nettype none

package lqwc_pkg;

	localparam int MOTOR_IDX_W = 3;
	localparam int BUCKET_IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int CNT_W = 16;

	localparam int DEF_MOTOR_COUNT = 8;
	localparam int DEF_BUCKET_MS = 100;
	localparam int DEF_BUCKET_COUNT = 10;

	localparam int QUEUE_DEPTH = 4;
	localparam int FRONT_STAGES = 3;
	// Front stages, queue entries, the read stage and the output register.
	localparam int INFLIGHT_MAX = FRONT_STAGES + QUEUE_DEPTH + 2;

	typedef struct packed {
		logic                    in_range;
		logic [MOTOR_IDX_W-1:0]  motor;
		logic                    pkt_valid;
		logic [BUCKET_IDX_W-1:0] bucket;
	} lqwc_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] invalid;
		logic [CNT_W-1:0] packets;
	} lqwc_cnt_t;

endpackage

`default_nettype wire

// ===== rtl/lqwc_front.sv =====
// Front part: takes words, maps the time stamp to a bucket and checks the motor number.
`default_nettype none

module lqwc_front import lqwc_pkg::*; #(
	parameter int MOTOR_COUNT = DEF_MOTOR_COUNT,
	parameter int BUCKET_MS = DEF_BUCKET_MS,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [MOTOR_IDX_W-1:0] in_motor,
	input  wire logic                   in_pkt_valid,
	input  wire logic [TIME_W-1:0]      in_time,
	output logic                        push,
	output lqwc_item_t                  push_item,
	input  wire logic                   queue_full
);

	// bucket = (time / BUCKET_MS) mod BUCKET_COUNT = (time mod PERIOD) / BUCKET_MS.
	localparam int PERIOD = BUCKET_MS * BUCKET_COUNT;
	localparam int REM_W = $clog2(PERIOD);
	localparam int QSHIFT = TIME_W + REM_W;
	localparam logic [63:0] RECIP =
		((64'd1 << QSHIFT) + 64'(PERIOD) - 64'd1) / 64'(PERIOD);
	localparam logic [16:0] M_LO = RECIP[16:0];
	localparam logic [15:0] M_HI = RECIP[32:17];
	localparam logic [REM_W-1:0] PERIOD_TRUNC = REM_W'(PERIOD);

	logic adv;
	logic vld_s1, vld_s2, vld_s3;
	logic [48:0] p_lo_s1;
	logic [47:0] p_hi_s1;
	logic [REM_W-1:0] t_lo_s1, t_lo_s2;
	logic [REM_W-1:0] q_s2;
	logic [REM_W-1:0] rem_s3;
	lqwc_item_t item_s1, item_s2, item_s3;
	logic [64:0] prod;
	logic [64:0] quot;
	logic [BUCKET_IDX_W-1:0] bucket;

	assign adv = !vld_s3 || !queue_full;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign prod = 65'(p_lo_s1) + (65'(p_hi_s1) << 17);
	assign quot = prod >> QSHIFT;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_lo_s1 <= 49'(in_time) * 49'(M_LO);
			p_hi_s1 <= 48'(in_time) * 48'(M_HI);
			t_lo_s1 <= in_time[REM_W-1:0];
			item_s1.in_range <= (32'(in_motor) < MOTOR_COUNT);
			item_s1.motor <= in_motor;
			item_s1.pkt_valid <= in_pkt_valid;
			item_s1.bucket <= '0;

			q_s2 <= quot[REM_W-1:0];
			t_lo_s2 <= t_lo_s1;
			item_s2 <= item_s1;

			// Only the low bits matter since the remainder is below 2**REM_W.
			rem_s3 <= t_lo_s2 - REM_W'(q_s2 * PERIOD_TRUNC);
			item_s3 <= item_s2;
		end
	end

	always_comb begin
		bucket = '0;
		for (int k = 1; k < BUCKET_COUNT; k++) begin
			if (rem_s3 >= REM_W'(k * BUCKET_MS)) begin
				bucket = bucket + BUCKET_IDX_W'(1);
			end
		end
	end

	always_comb begin
		push_item = item_s3;
		push_item.bucket = bucket;
	end

	assign push = vld_s3 && !queue_full;

endmodule

`default_nettype wire

// ===== rtl/lqwc_queue.sv =====
// Short queue that decouples the front part from the back part.
`default_nettype none

module lqwc_queue import lqwc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  lqwc_item_t       push_item,
	output logic             full,
	input  wire logic        pop,
	output lqwc_item_t       head_item,
	output logic             head_valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	lqwc_item_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lqwc_back.sv =====
// Back part: read-modify-write of the bucket memory and per-motor sums, and the result register.
`default_nettype none

module lqwc_back import lqwc_pkg::*; #(
	parameter int MOTOR_COUNT = DEF_MOTOR_COUNT,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  lqwc_item_t        head_item,
	input  wire logic         head_valid,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output lqwc_cnt_t         out_cnt
);

	localparam int MOTOR_W = (MOTOR_COUNT > 8) ? MOTOR_IDX_W :
		((MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1);
	localparam int BKT_W = $clog2(BUCKET_COUNT);
	localparam int ADDR_W = MOTOR_W + BKT_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	lqwc_cnt_t mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] ent_vld_q;
	logic [BKT_W-1:0] last_q [MOTOR_COUNT];
	lqwc_cnt_t sum_q [MOTOR_COUNT];

	logic vld_s1;
	lqwc_item_t item_s1;
	lqwc_cnt_t rd_s1;
	logic ent_vld_s1;
	logic fwd_s1;
	lqwc_cnt_t fwd_data_s1;

	logic out_valid_q;
	lqwc_cnt_t out_q;

	logic done;
	logic we;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [MOTOR_W-1:0] m_s1;
	logic change;
	logic [CNT_W-1:0] inc_inv;
	lqwc_cnt_t old, base, sum_base, new_ent, new_sum;

	assign done = vld_s1 && (!out_valid_q || out_ready);
	assign pop = head_valid && (!vld_s1 || done);
	assign we = done && item_s1.in_range;
	assign raddr = {head_item.motor[MOTOR_W-1:0], head_item.bucket[BKT_W-1:0]};
	assign waddr = {item_s1.motor[MOTOR_W-1:0], item_s1.bucket[BKT_W-1:0]};
	assign m_s1 = item_s1.motor[MOTOR_W-1:0];

	// A word that follows one to the same motor and bucket takes the freshly written counts.
	always_comb begin
		old = fwd_s1 ? fwd_data_s1 : (ent_vld_s1 ? rd_s1 : '0);
		change = (item_s1.bucket[BKT_W-1:0] != last_q[m_s1]);
		inc_inv = {{(CNT_W-1){1'b0}}, ~item_s1.pkt_valid};
		base = change ? '0 : old;
		sum_base.packets = change ? sum_q[m_s1].packets - old.packets : sum_q[m_s1].packets;
		sum_base.invalid = change ? sum_q[m_s1].invalid - old.invalid : sum_q[m_s1].invalid;
		new_ent.packets = base.packets + CNT_W'(1);
		new_ent.invalid = base.invalid + inc_inv;
		new_sum.packets = sum_base.packets + CNT_W'(1);
		new_sum.invalid = sum_base.invalid + inc_inv;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= new_ent;
		end
		if (pop) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ent_vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			ent_vld_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
				ent_vld_s1 <= ent_vld_q[raddr];
				fwd_s1 <= we && (waddr == raddr);
			end else if (done) begin
				vld_s1 <= 1'b0;
			end
			if (we) begin
				ent_vld_q[waddr] <= 1'b1;
				last_q[m_s1] <= item_s1.bucket[BKT_W-1:0];
				sum_q[m_s1] <= new_sum;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_item;
			fwd_data_s1 <= new_ent;
		end
		if (done) begin
			out_q <= item_s1.in_range ? new_sum : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_cnt = out_q;

endmodule

`default_nettype wire

// ===== rtl/link_quality_window_counter.sv =====
// Top level of the link quality window counter.
// Each input word is one telemetry packet (motor number, decode status, time in ms); each
// packet yields one output word with that motor's packet and invalid-packet totals over its
// ring of time buckets after the update, or zeros for a motor number of MOTOR_COUNT or
// more. A new word can be taken every clock cycle unless a full queue stalls intake. The
// result passes through the time-to-bucket reduction (reciprocal multiply in two partial
// products, remainder, bucket compare), the queue, the registered bucket-memory read and
// the update into the output register. A four-entry queue sits between the bucket
// reduction and the update, so a stalled output only stops intake once that queue fills.
// Back-to-back packets to one motor's bucket are served by forwarding the written counts.
`default_nettype none

module link_quality_window_counter import lqwc_pkg::*; #(
	parameter int MOTOR_COUNT = DEF_MOTOR_COUNT,
	parameter int BUCKET_MS = DEF_BUCKET_MS,
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] time_ms
	input  wire logic [3:0]  s_axis_tuser,  // [2:0] motor_index, [3] packet_valid
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // [15:0] window_packets, [31:16] window_invalid
);

	logic push, queue_full, pop, head_valid;
	lqwc_item_t push_item, head_item;
	lqwc_cnt_t out_cnt;

	lqwc_front #(
		.MOTOR_COUNT(MOTOR_COUNT),
		.BUCKET_MS(BUCKET_MS),
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_motor(s_axis_tuser[2:0]),
		.in_pkt_valid(s_axis_tuser[3]),
		.in_time(s_axis_tdata),
		.push(push),
		.push_item(push_item),
		.queue_full(queue_full)
	);

	lqwc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(queue_full),
		.pop(pop),
		.head_item(head_item),
		.head_valid(head_valid)
	);

	lqwc_back #(
		.MOTOR_COUNT(MOTOR_COUNT),
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_item(head_item),
		.head_valid(head_valid),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_cnt(out_cnt)
	);

	assign m_axis_tdata = {out_cnt.invalid, out_cnt.packets};

endmodule

`default_nettype wire

// ===== rtl/lqwc_checker.sv =====
// Port-level checker for the link quality window counter and its bind.
`default_nettype none

module lqwc_checker import lqwc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	localparam int FLY_W = $clog2(INFLIGHT_MAX + 2);

	logic [FLY_W-1:0] inflight_q;
	logic in_acc, out_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + FLY_W'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - FLY_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != '0)
		else $error("result word without an outstanding packet");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= FLY_W'(INFLIGHT_MAX))
		else $error("more packets outstanding than the block can hold");

endmodule

bind link_quality_window_counter lqwc_checker u_lqwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

`default_nettype wire
